### rtl/ebd_pkg.sv
package ebd_pkg;

  // Port widths
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;
  localparam int M_TUSER_W = 4;

  // Depth of the queue between front and back
  localparam int QDEPTH = 2;

  // Address map
  localparam logic [15:0] SND_BASE       = 16'h0450;
  localparam logic [15:0] SND_END        = 16'h0460;
  localparam logic [15:0] FM_ADDR_PORT   = 16'h0460;
  localparam logic [15:0] FM_DATA_PORT   = 16'h0461;
  localparam logic [15:0] RAM_BASE       = 16'h4000;
  localparam logic [15:0] RAM_END        = 16'h8000;
  localparam logic [15:0] CTL_BASE       = 16'h0470;
  localparam logic [15:0] CTL_END        = 16'h0480;
  localparam logic [15:0] CTL_MAIN       = 16'h0470;
  localparam logic [15:0] CTL_RAM_MODE   = 16'h0472;
  localparam logic [15:0] CTL_CPU_PAGE   = 16'h0478;
  localparam logic [15:0] CTL_VIDEO_PAGE = 16'h047C;

  // FM status auto-detect
  localparam logic [7:0] FM_DETECT_REG  = 8'd18;
  localparam logic [7:0] FM_DETECT_KEY  = 8'd252;
  localparam logic [7:0] DETECT_PERIOD  = 8'd129;
  localparam logic [7:0] DETECT_VALUE   = 8'd2;
  localparam logic [1:0] DETECT_RETURNS = 2'd2;

  // Result target codes
  localparam logic [2:0] TGT_NONE  = 3'd0;
  localparam logic [2:0] TGT_SOUND = 3'd1;
  localparam logic [2:0] TGT_FM    = 3'd2;
  localparam logic [2:0] TGT_RAM   = 3'd3;
  localparam logic [2:0] TGT_CTRL  = 3'd4;

  typedef enum logic [2:0] {
    REGION_NONE,
    REGION_SND,
    REGION_FM,
    REGION_RAM,
    REGION_CTL
  } region_t;

  typedef enum logic [2:0] {
    CSEL_NONE,
    CSEL_MAIN,
    CSEL_RAM_MODE,
    CSEL_CPU_PAGE,
    CSEL_VIDEO_PAGE
  } ctl_sel_t;

  // Classified bus access
  typedef struct packed {
    logic        wr;
    logic        dma;
    region_t     region;
    ctl_sel_t    ctl_sel;
    logic [13:0] offset;
    logic [7:0]  wdata;
    logic [7:0]  fm_status;
    logic [7:0]  snd_data;
  } item_t;

endpackage

### rtl/expansion_bus_decoder_banked_ram.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: bus_address, write_data,
//                                              fm_status_in, sound_read_in
//                                              tuser: opcode, video_dma
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: read_data, chip_register,
//                                              chip_data; tuser: target, chip_write
//
// Throughput is one item per clock while m_axis is not stalled; an accepted item is
// held in the queue, then registered in the back stage with the RAM read port.
// After reset the back part sweeps all RAM_BYTES bytes of RAM with zeros, one byte a
// cycle; s_axis_tready stays low for that whole sweep.
// A stall on m_axis holds the output register; the two-entry queue absorbs items
// already in flight and then drops s_axis_tready.
module expansion_bus_decoder_banked_ram #(
  parameter int RAM_BYTES = 131072
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // bus_address[15:0], write_data[23:16], fm_status_in[31:24], sound_read_in[39:32]
  input  logic [ebd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // opcode[0], video_dma[1]
  input  logic [ebd_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // read_data[7:0], chip_register[15:8], chip_data[23:16]
  output logic [ebd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // target[2:0], chip_write[3]
  output logic [ebd_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

  logic           clr_busy;
  logic           q_ready;
  logic           q_push;
  ebd_pkg::item_t q_in_item;
  logic           q_valid;
  logic           q_pop;
  ebd_pkg::item_t q_out_item;

  // Front: accept items and classify the address window
  ebd_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .clr_busy      (clr_busy),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_item        (q_in_item)
  );

  // Short queue: decouple front acceptance from back stalls
  ebd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_out_item)
  );

  // Back: apply enables, update control/FM state, access RAM, hold the result
  ebd_back #(
    .RAM_BYTES (RAM_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_out_item),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .clr_busy      (clr_busy)
  );

`ifndef NO_ASSERTIONS
  // No item enters while the RAM sweep runs
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s_axis_tready)
    else $error("item accepted during RAM clear");

  // No result can exist before the sweep ends
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !m_axis_tvalid)
    else $error("result issued during RAM clear");

  // Only sound and FM targets forward a chip write
  a_chip_write_target: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[3]) |->
      (m_axis_tuser[2:0] == ebd_pkg::TGT_SOUND || m_axis_tuser[2:0] == ebd_pkg::TGT_FM))
    else $error("chip write on a non-chip target");
`endif

endmodule

### rtl/ebd_front.sv
module ebd_front (
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // bus_address[15:0], write_data[23:16], fm_status_in[31:24], sound_read_in[39:32]
  input  logic [ebd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // opcode[0], video_dma[1]
  input  logic [ebd_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  input  logic                            clr_busy,
  input  logic                            q_ready,
  output logic                            q_push,
  output ebd_pkg::item_t                  q_item
);

  logic [15:0] addr;

  assign addr          = s_axis_tdata[15:0];
  assign s_axis_tready = q_ready && !clr_busy;
  assign q_push        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    q_item           = '0;
    q_item.wr        = s_axis_tuser[0];
    q_item.dma       = s_axis_tuser[1];
    q_item.offset    = addr[13:0];
    q_item.wdata     = s_axis_tdata[23:16];
    q_item.fm_status = s_axis_tdata[31:24];
    q_item.snd_data  = s_axis_tdata[39:32];

    // windows are disjoint; enables are applied in the back part
    if (addr >= ebd_pkg::SND_BASE && addr < ebd_pkg::SND_END) begin
      q_item.region = ebd_pkg::REGION_SND;
    end else if (addr == ebd_pkg::FM_ADDR_PORT || addr == ebd_pkg::FM_DATA_PORT) begin
      q_item.region = ebd_pkg::REGION_FM;
    end else if (addr >= ebd_pkg::RAM_BASE && addr < ebd_pkg::RAM_END) begin
      q_item.region = ebd_pkg::REGION_RAM;
    end else if (addr >= ebd_pkg::CTL_BASE && addr < ebd_pkg::CTL_END) begin
      q_item.region = ebd_pkg::REGION_CTL;
    end else begin
      q_item.region = ebd_pkg::REGION_NONE;
    end

    unique case (addr)
      ebd_pkg::CTL_MAIN:       q_item.ctl_sel = ebd_pkg::CSEL_MAIN;
      ebd_pkg::CTL_RAM_MODE:   q_item.ctl_sel = ebd_pkg::CSEL_RAM_MODE;
      ebd_pkg::CTL_CPU_PAGE:   q_item.ctl_sel = ebd_pkg::CSEL_CPU_PAGE;
      ebd_pkg::CTL_VIDEO_PAGE: q_item.ctl_sel = ebd_pkg::CSEL_VIDEO_PAGE;
      default:                 q_item.ctl_sel = ebd_pkg::CSEL_NONE;
    endcase
  end

endmodule

### rtl/ebd_queue.sv
module ebd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ebd_pkg::item_t push_item,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output ebd_pkg::item_t pop_item
);

  localparam int PW = (ebd_pkg::QDEPTH > 1) ? $clog2(ebd_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(ebd_pkg::QDEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(ebd_pkg::QDEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(ebd_pkg::QDEPTH);

  ebd_pkg::item_t entry [ebd_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/ebd_back.sv
module ebd_back #(
  parameter int RAM_BYTES = 131072
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  ebd_pkg::item_t                  q_item,
  output logic                            q_pop,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // read_data[7:0], chip_register[15:8], chip_data[23:16]
  output logic [ebd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // target[2:0], chip_write[3]
  output logic [ebd_pkg::M_TUSER_W-1:0]   m_axis_tuser,
  output logic                            clr_busy
);

  localparam int AW = $clog2(RAM_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(RAM_BYTES - 1);
  localparam logic [19:0]   RAM_SIZE = 20'(RAM_BYTES);

  // Fold a 17-bit page index into the RAM; exact while the quotient does not exceed 7.
  function automatic logic [16:0] wrap_idx(input logic [16:0] v);
    logic [19:0] r;
    r = {3'b000, v};
    for (int k = 2; k >= 0; k--) begin
      if (r >= (RAM_SIZE << k)) begin
        r = r - (RAM_SIZE << k);
      end
    end
    return r[16:0];
  endfunction

  logic [7:0] ram [RAM_BYTES];
  logic [7:0] ram_q;
  logic [AW-1:0] clr_addr;

  logic [7:0] main_control;
  logic [7:0] cpu_page_select;
  logic [7:0] video_page_select;
  logic [7:0] ram_mode_control;
  logic [7:0] fm_address_latch;
  logic [7:0] detect_countdown;
  logic       detect_idle;
  logic [7:0] detect_reload;
  logic [1:0] detect_returns_left;

  logic [7:0] main_control_next;
  logic [7:0] cpu_page_select_next;
  logic [7:0] video_page_select_next;
  logic [7:0] ram_mode_control_next;
  logic [7:0] fm_address_latch_next;
  logic [7:0] detect_countdown_next;
  logic       detect_idle_next;
  logic [7:0] detect_reload_next;
  logic [1:0] detect_returns_left_next;

  logic [7:0] res_rd;
  logic       res_use_ram;
  logic [2:0] res_tgt;
  logic       res_cw;
  logic [7:0] res_creg;
  logic [7:0] res_cdata;

  logic [7:0] res_rd_next;
  logic       res_use_ram_next;
  logic [2:0] res_tgt_next;
  logic       res_cw_next;
  logic [7:0] res_creg_next;
  logic [7:0] res_cdata_next;

  logic        fire;
  logic        ram_we;
  logic        ram_re;
  logic [16:0] idx_raw;
  logic [16:0] idx_wrap;
  logic [AW-1:0] ram_idx;
  logic [7:0]  page_sel;
  logic        snd_en;
  logic        win0_en;
  logic        win1_en;
  logic        fm_en;
  logic        mode48;
  logic        rd_block;
  logic        ram_en;

  assign fire  = q_valid && (!m_axis_tvalid || m_axis_tready);
  assign q_pop = fire;

  assign snd_en   = main_control[4];
  assign win0_en  = main_control[5];
  assign win1_en  = main_control[6];
  assign fm_en    = main_control[7];
  assign mode48   = ram_mode_control[0];
  assign rd_block = ram_mode_control[1];
  assign ram_en   = mode48 || win0_en || win1_en;

  // RAM index: linear in 48K mode, otherwise page number over an 8 KB window
  always_comb begin
    page_sel = (!q_item.wr && q_item.dma) ? video_page_select : cpu_page_select;
    if (mode48) begin
      idx_raw = {3'b000, q_item.offset};
    end else if (!q_item.offset[13]) begin
      idx_raw = {page_sel[3:0], q_item.offset[12:0]};
      idx_raw[8] = idx_raw[8] | (!q_item.wr && main_control[0]);
    end else begin
      idx_raw = {page_sel[7:4], q_item.offset[12:0]};
      idx_raw[8] = idx_raw[8] | (!q_item.wr && main_control[1]);
    end
    idx_wrap = wrap_idx(idx_raw);
    ram_idx  = idx_wrap[AW-1:0];
  end

  always_comb begin
    main_control_next        = main_control;
    cpu_page_select_next     = cpu_page_select;
    video_page_select_next   = video_page_select;
    ram_mode_control_next    = ram_mode_control;
    fm_address_latch_next    = fm_address_latch;
    detect_countdown_next    = detect_countdown;
    detect_idle_next         = detect_idle;
    detect_reload_next       = detect_reload;
    detect_returns_left_next = detect_returns_left;
    res_rd_next              = '0;
    res_use_ram_next         = 1'b0;
    res_tgt_next             = ebd_pkg::TGT_NONE;
    res_cw_next              = 1'b0;
    res_creg_next            = '0;
    res_cdata_next           = '0;
    ram_we                   = 1'b0;
    ram_re                   = 1'b0;

    if (q_item.region == ebd_pkg::REGION_SND && snd_en) begin
      res_tgt_next  = ebd_pkg::TGT_SOUND;
      res_creg_next = {4'h0, q_item.offset[3:0]};
      if (q_item.wr) begin
        res_cw_next    = 1'b1;
        res_cdata_next = q_item.wdata;
      end else begin
        res_rd_next = q_item.snd_data;
      end
    end else if (q_item.region == ebd_pkg::REGION_FM && fm_en) begin
      res_tgt_next  = ebd_pkg::TGT_FM;
      res_creg_next = fm_address_latch;
      if (q_item.wr) begin
        if (q_item.offset[0]) begin
          res_cw_next    = 1'b1;
          res_cdata_next = q_item.wdata;
          if (fm_address_latch == ebd_pkg::FM_DETECT_REG &&
              q_item.wdata == ebd_pkg::FM_DETECT_KEY) begin
            detect_reload_next    = ebd_pkg::DETECT_PERIOD;
            detect_countdown_next = ebd_pkg::DETECT_PERIOD;
            detect_idle_next      = 1'b0;
          end
        end else begin
          fm_address_latch_next = q_item.wdata;
          res_creg_next         = q_item.wdata;
        end
      end else if (q_item.offset[0]) begin
        res_rd_next = q_item.fm_status;
        if (!detect_idle) begin
          if (detect_countdown != '0) begin
            detect_countdown_next = detect_countdown - 1'b1;
          end else if (detect_returns_left != '0) begin
            res_rd_next              = ebd_pkg::DETECT_VALUE;
            detect_countdown_next    = detect_reload;
            detect_returns_left_next = detect_returns_left - 1'b1;
            detect_idle_next         = (detect_returns_left == 2'd1);
          end
        end
      end
    end else if (q_item.region == ebd_pkg::REGION_RAM && ram_en) begin
      res_tgt_next = ebd_pkg::TGT_RAM;
      // a window that is switched off decodes but never touches RAM
      if (mode48 || (!q_item.offset[13] && win0_en) || (q_item.offset[13] && win1_en)) begin
        if (q_item.wr) begin
          ram_we = 1'b1;
        end else if (!rd_block) begin
          ram_re           = 1'b1;
          res_use_ram_next = 1'b1;
        end
      end
    end else if (q_item.region == ebd_pkg::REGION_CTL && q_item.wr) begin
      res_tgt_next = ebd_pkg::TGT_CTRL;
      unique case (q_item.ctl_sel)
        ebd_pkg::CSEL_MAIN:       main_control_next      = q_item.wdata;
        ebd_pkg::CSEL_RAM_MODE:   ram_mode_control_next  = q_item.wdata;
        ebd_pkg::CSEL_CPU_PAGE:   cpu_page_select_next   = q_item.wdata;
        ebd_pkg::CSEL_VIDEO_PAGE: video_page_select_next = q_item.wdata;
        default: ;
      endcase
    end
  end

  // RAM: clearing sweep after reset owns the write port
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      ram[clr_addr] <= '0;
    end else if (fire && ram_we) begin
      ram[ram_idx] <= q_item.wdata;
    end
    if (fire && ram_re) begin
      ram_q <= ram[ram_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy            <= 1'b1;
      clr_addr            <= '0;
      m_axis_tvalid       <= 1'b0;
      main_control        <= '0;
      cpu_page_select     <= '0;
      video_page_select   <= '0;
      ram_mode_control    <= '0;
      fm_address_latch    <= '0;
      detect_countdown    <= '0;
      detect_idle         <= 1'b1;
      detect_reload       <= '0;
      detect_returns_left <= ebd_pkg::DETECT_RETURNS;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == CLR_LAST) begin
          clr_busy <= 1'b0;
        end
      end
      if (fire) begin
        m_axis_tvalid       <= 1'b1;
        main_control        <= main_control_next;
        cpu_page_select     <= cpu_page_select_next;
        video_page_select   <= video_page_select_next;
        ram_mode_control    <= ram_mode_control_next;
        fm_address_latch    <= fm_address_latch_next;
        detect_countdown    <= detect_countdown_next;
        detect_idle         <= detect_idle_next;
        detect_reload       <= detect_reload_next;
        detect_returns_left <= detect_returns_left_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_rd      <= res_rd_next;
      res_use_ram <= res_use_ram_next;
      res_tgt     <= res_tgt_next;
      res_cw      <= res_cw_next;
      res_creg    <= res_creg_next;
      res_cdata   <= res_cdata_next;
    end
  end

  assign m_axis_tdata = {res_cdata, res_creg, res_use_ram ? ram_q : res_rd};
  assign m_axis_tuser = {res_cw, res_tgt};

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAM_BYTES    = 131072;
  // Longest quiet stretch is the RAM clear after reset; allow it several times over.
  localparam int QUIET_LIMIT  = 4 * RAM_BYTES;
  // Random items beside the directed part and the status override burst
  localparam int RANDOM_ITEMS = 150;
  localparam int MAX_PRINTS   = 30;

  // Idling phases
  localparam int PH_FLAT       = 0;
  localparam int PH_SEND_IDLE  = 1;
  localparam int PH_RECV_STALL = 2;
  localparam int PH_BOTH       = 3;

  localparam bit OP_READ  = 1'b0;
  localparam bit OP_WRITE = 1'b1;

  int send_idle_pct [4] = '{0, 81, 0, 11};
  int recv_stall_pct[4] = '{0, 0, 81, 11};

  typedef struct {
    bit          wr;
    logic [15:0] addr;
    logic [7:0]  wdata;
    bit          dma;
    logic [7:0]  fm_status;
    logic [7:0]  snd_data;
    bit          drain;   // hold this item until every pending result is back
    int          phase;
  } bus_access_t;

  typedef struct {
    logic [7:0] read_data;
    logic [2:0] target;
    logic       chip_write;
    logic [7:0] chip_register;
    logic [7:0] chip_data;
  } decode_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [ebd_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [ebd_pkg::S_TUSER_W-1:0] s_axis_tuser  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [ebd_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic [ebd_pkg::M_TUSER_W-1:0] m_axis_tuser;

  expansion_bus_decoder_banked_ram #(
    .RAM_BYTES(RAM_BYTES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bus accesses waiting to be offered, and decode results waiting to come back
  bus_access_t    pending_accesses[$];
  decode_result_t expected_decodes[$];
  bus_access_t    held_access;

  int n_queued     = 0;
  int n_directed   = 0;
  int n_accepted   = 0;
  int n_results    = 0;
  int n_mismatch   = 0;
  int n_overrides  = 0;
  int gen_phase    = PH_FLAT;
  int cur_phase    = PH_FLAT;
  bit drain_next   = 1'b0;

  // ---------------------------------------------------------------------------
  // Shadow copy of the decoder state
  // ---------------------------------------------------------------------------
  logic [7:0] ram_image[RAM_BYTES];
  logic [7:0] main_ctl;
  logic [7:0] cpu_page;
  logic [7:0] video_page;
  logic [7:0] ram_mode;
  logic [7:0] fm_latch;
  logic [7:0] det_count;
  logic       det_idle;
  logic [7:0] det_reload;
  logic [1:0] det_returns;

  task automatic clear_shadow();
    for (int i = 0; i < RAM_BYTES; i++) ram_image[i] = 8'h00;
    main_ctl    = 8'h00;
    cpu_page    = 8'h00;
    video_page  = 8'h00;
    ram_mode    = 8'h00;
    fm_latch    = 8'h00;
    det_count   = 8'h00;
    det_idle    = 1'b1;
    det_reload  = 8'h00;
    det_returns = ebd_pkg::DETECT_RETURNS;
  endtask

  // Decode one bus access against the shadow state; update the state as the block would.
  function automatic decode_result_t decode_access(input bus_access_t a);
    decode_result_t r;
    logic        snd_en, win0_en, win1_en, fm_en, mode48, rd_block, ram_en, hit;
    logic [13:0] off;
    logic [7:0]  sel;
    int unsigned idx;
    r        = '{default: '0};
    snd_en   = main_ctl[4];
    win0_en  = main_ctl[5];
    win1_en  = main_ctl[6];
    fm_en    = main_ctl[7];
    mode48   = ram_mode[0];
    rd_block = ram_mode[1];
    ram_en   = mode48 || win0_en || win1_en;
    hit      = 1'b0;
    idx      = 0;

    if (snd_en && a.addr >= ebd_pkg::SND_BASE && a.addr < ebd_pkg::SND_END) begin
      r.target        = ebd_pkg::TGT_SOUND;
      r.chip_register = 8'(a.addr - ebd_pkg::SND_BASE);
      if (a.wr) begin
        r.chip_write = 1'b1;
        r.chip_data  = a.wdata;
      end else begin
        r.read_data = a.snd_data;
      end
    end else if (fm_en && (a.addr == ebd_pkg::FM_ADDR_PORT ||
                           a.addr == ebd_pkg::FM_DATA_PORT)) begin
      r.target = ebd_pkg::TGT_FM;
      if (a.wr) begin
        if (a.addr == ebd_pkg::FM_DATA_PORT) begin
          r.chip_write = 1'b1;
          r.chip_data  = a.wdata;
          // Arm the status override on the detect key
          if (fm_latch == ebd_pkg::FM_DETECT_REG && a.wdata == ebd_pkg::FM_DETECT_KEY) begin
            det_reload = ebd_pkg::DETECT_PERIOD;
            det_count  = ebd_pkg::DETECT_PERIOD;
            det_idle   = 1'b0;
          end
        end else begin
          fm_latch = a.wdata;
        end
      end else if (a.addr == ebd_pkg::FM_DATA_PORT) begin
        r.read_data = a.fm_status;
        if (!det_idle) begin
          if (det_count != 0) begin
            det_count--;
          end else if (det_returns != 0) begin
            r.read_data = ebd_pkg::DETECT_VALUE;
            det_count   = det_reload;
            det_returns--;
            n_overrides++;
            if (det_returns == 0) det_idle = 1'b1;
          end
        end
      end
      r.chip_register = fm_latch;
    end else if (ram_en && a.addr >= ebd_pkg::RAM_BASE && a.addr < ebd_pkg::RAM_END) begin
      r.target = ebd_pkg::TGT_RAM;
      off      = 14'(a.addr - ebd_pkg::RAM_BASE);
      // DMA only steers reads to the video page register
      sel      = (!a.wr && a.dma) ? video_page : cpu_page;
      if (mode48) begin
        hit = 1'b1;
        idx = 32'(off);
      end else if (!off[13]) begin
        if (win0_en) begin
          hit = 1'b1;
          idx = (32'(sel[3:0]) << 13) | 32'(off[12:0]);
          if (!a.wr) idx |= 32'(main_ctl[0]) << 8;
        end
      end else if (win1_en) begin
        hit = 1'b1;
        idx = (32'(sel[7:4]) << 13) | 32'(off[12:0]);
        if (!a.wr) idx |= 32'(main_ctl[1]) << 8;
      end
      if (hit) begin
        idx = idx % RAM_BYTES;
        if (a.wr) ram_image[idx] = a.wdata;
        else if (!rd_block) r.read_data = ram_image[idx];
      end
    end else if (a.wr && a.addr >= ebd_pkg::CTL_BASE && a.addr < ebd_pkg::CTL_END) begin
      r.target = ebd_pkg::TGT_CTRL;
      case (a.addr)
        ebd_pkg::CTL_MAIN:       main_ctl   = a.wdata;
        ebd_pkg::CTL_CPU_PAGE:   cpu_page   = a.wdata;
        ebd_pkg::CTL_VIDEO_PAGE: video_page = a.wdata;
        ebd_pkg::CTL_RAM_MODE:   ram_mode   = a.wdata;
        default: ;  // unused control slots only decode
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_access(input bit wr, input logic [15:0] addr, input logic [7:0] data,
                              input bit dma);
    bus_access_t a;
    a.wr        = wr;
    a.addr      = addr;
    a.wdata     = data;
    a.dma       = dma;
    a.fm_status = 8'($urandom);
    a.snd_data  = 8'($urandom);
    a.drain     = drain_next;
    a.phase     = gen_phase;
    drain_next  = 1'b0;
    pending_accesses.push_back(a);
    n_queued++;
  endtask

  task automatic report_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got_v,
                             input logic [7:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("result %0d %s got %h want %h", n_results, name, got_v,
                                want_v));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued accesses on s_axis, predict each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : feed_proc
    logic fire;
    logic offer;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      fire  = s_axis_tvalid && s_axis_tready;
      offer = s_axis_tvalid && !fire;   // hold an item the block has not taken yet
      if (fire) begin
        expected_decodes.push_back(decode_access(held_access));
        n_accepted++;
      end
      if (!offer && pending_accesses.size() != 0) begin
        // Hold off a drain item until the pipe is empty
        if (!(pending_accesses[0].drain && expected_decodes.size() != 0)) begin
          cur_phase = pending_accesses[0].phase;
          if ($urandom_range(99) >= send_idle_pct[cur_phase]) begin
            held_access  = pending_accesses.pop_front();
            offer        = 1'b1;
            s_axis_tdata <= {held_access.snd_data, held_access.fm_status,
                             held_access.wdata, held_access.addr};
            s_axis_tuser <= {held_access.dma, held_access.wr};
          end
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take results from m_axis and compare with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sink_proc
    decode_result_t got;
    decode_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.read_data     = m_axis_tdata[7:0];
        got.chip_register = m_axis_tdata[15:8];
        got.chip_data     = m_axis_tdata[23:16];
        got.target        = m_axis_tuser[2:0];
        got.chip_write    = m_axis_tuser[3];
        if (expected_decodes.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending", n_results));
        end else begin
          want = expected_decodes.pop_front();
          check_field("read_data", got.read_data, want.read_data);
          check_field("target", {5'd0, got.target}, {5'd0, want.target});
          check_field("chip_write", {7'd0, got.chip_write}, {7'd0, want.chip_write});
          check_field("chip_register", got.chip_register, want.chip_register);
          check_field("chip_data", got.chip_data, want.chip_data);
        end
        n_results++;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct[cur_phase]);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when neither side moves for too long
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int          n_rand;
    int          burst_len;
    int          kind;
    int          k;
    int          base;
    bit          burst_done;
    logic [7:0]  val;
    logic [15:0] addr;

    clear_shadow();

    // Directed part: all decode paths, window edges and the corner cases
    gen_phase = PH_FLAT;
    queue_access(OP_READ,  ebd_pkg::RAM_BASE,        8'h00, 1'b0);  // RAM not enabled yet
    queue_access(OP_READ,  16'h0455,                 8'hFF, 1'b0);  // sound window disabled
    queue_access(OP_WRITE, ebd_pkg::CTL_MAIN,        8'hF0, 1'b0);  // sound, windows, FM
    queue_access(OP_WRITE, ebd_pkg::CTL_CPU_PAGE,    8'h21, 1'b0);
    queue_access(OP_WRITE, ebd_pkg::CTL_VIDEO_PAGE,  8'hF3, 1'b0);
    queue_access(OP_WRITE, ebd_pkg::SND_END - 16'd1, 8'hFF, 1'b0);
    queue_access(OP_READ,  ebd_pkg::SND_BASE,        8'h00, 1'b1);
    queue_access(OP_WRITE, ebd_pkg::FM_ADDR_PORT,    ebd_pkg::FM_DETECT_REG, 1'b0);
    queue_access(OP_WRITE, ebd_pkg::FM_DATA_PORT,    ebd_pkg::FM_DETECT_KEY, 1'b0);
    queue_access(OP_READ,  ebd_pkg::FM_DATA_PORT,    8'h00, 1'b0);
    queue_access(OP_READ,  ebd_pkg::FM_ADDR_PORT,    8'h00, 1'b0);  // FM address port reads 0
    queue_access(OP_WRITE, ebd_pkg::RAM_BASE,        8'hA5, 1'b1);  // DMA ignored on writes
    queue_access(OP_WRITE, ebd_pkg::RAM_END - 16'd1, 8'h5A, 1'b0);
    queue_access(OP_READ,  ebd_pkg::RAM_BASE,        8'h00, 1'b0);
    queue_access(OP_READ,  ebd_pkg::RAM_END - 16'd1, 8'h00, 1'b1);  // DMA read, video page
    queue_access(OP_WRITE, ebd_pkg::CTL_MAIN,        8'hF3, 1'b0);  // OR bit 8 into reads
    queue_access(OP_READ,  ebd_pkg::RAM_BASE,        8'h00, 1'b0);
    queue_access(OP_WRITE, ebd_pkg::CTL_RAM_MODE,    8'h03, 1'b0);  // 48K and reads blocked
    queue_access(OP_READ,  16'h5000,                 8'h00, 1'b0);
    queue_access(OP_WRITE, ebd_pkg::CTL_RAM_MODE,    8'h01, 1'b0);
    queue_access(OP_READ,  ebd_pkg::RAM_END - 16'd1, 8'h00, 1'b0);
    queue_access(OP_WRITE, ebd_pkg::CTL_MAIN,        8'hA0, 1'b0);  // window 1 disabled
    queue_access(OP_WRITE, ebd_pkg::CTL_RAM_MODE,    8'h00, 1'b0);
    queue_access(OP_READ,  16'h6000,                 8'h00, 1'b0);
    queue_access(OP_WRITE, 16'h7000,                 8'h77, 1'b0);  // ignored write
    queue_access(OP_READ,  ebd_pkg::CTL_BASE,        8'h00, 1'b0);  // control reads: nothing
    queue_access(OP_WRITE, ebd_pkg::CTL_BASE + 16'd1, 8'hFF, 1'b0); // unused control register at offset 1
    queue_access(OP_WRITE, 16'hFFFF,                 8'hFF, 1'b1);
    queue_access(OP_READ,  16'h0000,                 8'h00, 1'b0);
    n_directed = n_queued;

    // Random part: mostly well-formed setup/access sequences, with some noise
    burst_len  = 0;
    burst_done = 1'b0;
    n_rand     = 0;
    while (n_rand < RANDOM_ITEMS) begin
      gen_phase = (n_rand * 4 / RANDOM_ITEMS) % 4;
      if (!burst_done && n_rand > 40) begin
        // Pause until drained, then run the status override through both returns
        burst_done = 1'b1;
        k          = n_queued;
        drain_next = 1'b1;
        queue_access(OP_WRITE, ebd_pkg::CTL_MAIN, 8'h80 | 8'($urandom_range(127)), 1'b0);
        queue_access(OP_WRITE, ebd_pkg::FM_ADDR_PORT, ebd_pkg::FM_DETECT_REG, 1'b0);
        queue_access(OP_WRITE, ebd_pkg::FM_DATA_PORT, ebd_pkg::FM_DETECT_KEY, 1'b0);
        repeat (2 * (int'(ebd_pkg::DETECT_PERIOD) + 1) + 6)
          queue_access(OP_READ, ebd_pkg::FM_DATA_PORT, 8'($urandom), 1'($urandom_range(1)));
        burst_len = n_queued - k;
      end else begin
        kind = $urandom_range(99);
        if (kind < 12) begin
          val = 8'($urandom);
          if ($urandom_range(3) != 0) val |= 8'h70;
          queue_access(OP_WRITE, ebd_pkg::CTL_MAIN, val, 1'($urandom_range(1)));
          val = 8'($urandom) & 8'hFC;
          if ($urandom_range(3) == 0) val[0] = 1'b1;
          if ($urandom_range(4) == 0) val[1] = 1'b1;
          queue_access(OP_WRITE, ebd_pkg::CTL_RAM_MODE, val, 1'b0);
          queue_access(OP_WRITE, ebd_pkg::CTL_CPU_PAGE, 8'($urandom), 1'b0);
          queue_access(OP_WRITE, ebd_pkg::CTL_VIDEO_PAGE, 8'($urandom), 1'b0);
        end else if (kind < 45) begin
          // Write a short run of bytes, maybe flip pages, then read the run back
          k    = $urandom_range(6, 1);
          base = $urandom_range(16'h3FFF);
          for (int i = 0; i < k; i++) begin
            addr = ebd_pkg::RAM_BASE | 16'((base + i) & 16'h3FFF);
            queue_access(OP_WRITE, addr, 8'($urandom), 1'($urandom_range(1)));
          end
          if ($urandom_range(3) == 0)
            queue_access(OP_WRITE, ebd_pkg::CTL_CPU_PAGE, 8'($urandom), 1'b0);
          for (int i = 0; i < k; i++) begin
            addr = ebd_pkg::RAM_BASE | 16'((base + i) & 16'h3FFF);
            queue_access(OP_READ, addr, 8'($urandom), 1'($urandom_range(1)));
          end
        end else if (kind < 60) begin
          repeat ($urandom_range(4, 1))
            queue_access(1'($urandom_range(1)), ebd_pkg::SND_BASE + 16'($urandom_range(15)),
                         8'($urandom), 1'($urandom_range(1)));
        end else if (kind < 75) begin
          val = ($urandom_range(2) == 0) ? ebd_pkg::FM_DETECT_REG : 8'($urandom);
          queue_access(OP_WRITE, ebd_pkg::FM_ADDR_PORT, val, 1'b0);
          val = ($urandom_range(2) == 0) ? ebd_pkg::FM_DETECT_KEY : 8'($urandom);
          queue_access(OP_WRITE, ebd_pkg::FM_DATA_PORT, val, 1'b0);
          repeat ($urandom_range(6, 1))
            queue_access(OP_READ, ebd_pkg::FM_DATA_PORT, 8'($urandom), 1'($urandom_range(1)));
          if ($urandom_range(1) == 0)
            queue_access(OP_READ, ebd_pkg::FM_ADDR_PORT, 8'($urandom), 1'b0);
        end else begin
          // Noise: anywhere on the bus, or close to the chip and control windows
          repeat ($urandom_range(4, 1)) begin
            addr = ($urandom_range(1) == 0) ? 16'($urandom)
                                            : 16'h0400 + 16'($urandom_range(255));
            queue_access(1'($urandom_range(1)), addr, 8'($urandom), 1'($urandom_range(1)));
          end
        end
      end
      n_rand = n_queued - n_directed - burst_len;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_queued) @(posedge clk);
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_decodes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_decodes.size()));

    $display("Ran %0d bus accesses (%0d directed) through four idling phases; %0d checked.",
             n_queued, n_directed, n_results);
    $display("FM status override fired %0d times; %0d mismatches seen.", n_overrides, n_mismatch);
    if (n_mismatch == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
rtl/ebd_pkg.sv
rtl/ebd_front.sv
rtl/ebd_queue.sv
rtl/ebd_back.sv
rtl/expansion_bus_decoder_banked_ram.sv
tb/testbench.sv
